[rtl/mie_pkg.sv]
// Package for the modular inverse block: word types, sequencer states and
// the control and status bundles of the shift-subtract unit. No dependencies.
`timescale 1ns / 1ps

package mie_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] inverse;
        logic              no_inverse;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUB,
        ST_POST,
        ST_FIX,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic sub;
    } t_du_cmd;

    typedef struct packed {
        logic grow;
        logic last;
    } t_du_stat;

endpackage

[rtl/mie_divunit.sv]
// Shared shift-subtract unit: aligns the divisor, then subtracts one
// quotient bit per cycle while accumulating the Bezout coefficient.
// Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_divunit import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  t_du_cmd          i_cmd,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_div,
    input  logic [WIDTH-1:0] i_uacc,
    input  logic [WIDTH-1:0] i_ush,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_uacc,
    output t_du_stat         o_stat
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_div;
    logic [WIDTH-1:0] r_uacc;
    logic [WIDTH-1:0] r_ush;
    logic [CW-1:0]    r_cnt;
    logic             ge;

    assign ge = (r_rem >= r_div);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= i_rem;
            r_div  <= i_div;
            r_uacc <= i_uacc;
            r_ush  <= i_ush;
            r_cnt  <= '0;
        end else if (i_cmd.shift) begin
            r_div <= {r_div[WIDTH-2:0], 1'b0};
            r_ush <= {r_ush[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.sub) begin
            if (ge) begin
                r_rem  <= r_rem - r_div;
                r_uacc <= r_uacc + r_ush;
            end
            r_div <= {1'b0, r_div[WIDTH-1:1]};
            r_ush <= {1'b0, r_ush[WIDTH-1:1]};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rem       = r_rem;
    assign o_uacc      = r_uacc;
    assign o_stat.grow = ({r_div, 1'b0} <= {1'b0, r_rem});
    assign o_stat.last = (r_cnt == '0);

endmodule

[rtl/modular_inverse_euclid.sv]
// Modular inverse by the extended Euclidean algorithm: sequencer, pair and
// coefficient registers, output register. Depends on mie_pkg, mie_divunit.
//
// Usage: the input channel (i_in_valid, o_in_stall, i_in_data) takes one
// word holding a value and a modulus. The output channel (o_out_valid,
// i_out_stall, o_out_data) returns one word per input: the inverse in
// 0..modulus-1 and a no_inverse flag, with inverse zero when the gcd is
// not one or the modulus is below two. Arithmetic runs at WIDTH bits; the
// inputs are cut to their low WIDTH bits.
// Each division step, the reduction of value by modulus included, runs
// ST_SHIFT, where the shift-subtract unit aligns the divisor, ST_SUB, where
// it subtracts quotient bits, and ST_POST, where the remainder pair and
// coefficients are updated; ST_FIX then settles the flag and ST_FIN writes
// the output register. A modulus below two goes straight to ST_FIN.
// One word is processed at a time: o_in_stall stays high from acceptance
// until the result is written to the output register; only then is the
// next word taken. A stalled result is held there; the sequencer waits
// in its final state until it can write. Reset (synchronous, active low)
// returns to idle and drops any pending result word.
`timescale 1ns / 1ps

module modular_inverse_euclid import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int EW = WIDTH + DATA_W;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    t_out             r_out;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_r0;
    logic [WIDTH-1:0] r_r1;
    logic [WIDTH-1:0] r_u0;
    logic [WIDTH-1:0] r_u1;
    logic             r_pos;
    logic             r_red;
    logic             r_fail;

    logic [EW-1:0]    a_ext;
    logic [EW-1:0]    m_ext;
    logic [EW-1:0]    inv_ext;
    logic [WIDTH-1:0] a_in;
    logic [WIDTH-1:0] m_in;
    logic [WIDTH-1:0] inv_w;
    logic             in_acc;
    logic             out_free;
    logic             m_small;

    t_du_cmd          du_cmd;
    t_du_stat         du_stat;
    logic [WIDTH-1:0] du_rem;
    logic [WIDTH-1:0] du_uacc;
    logic [WIDTH-1:0] ld_rem;
    logic [WIDTH-1:0] ld_div;
    logic [WIDTH-1:0] ld_uacc;
    logic [WIDTH-1:0] ld_ush;

    assign a_ext   = {{WIDTH{1'b0}}, i_in_data.value};
    assign m_ext   = {{WIDTH{1'b0}}, i_in_data.modulus};
    assign a_in    = a_ext[WIDTH-1:0];
    assign m_in    = m_ext[WIDTH-1:0];
    assign m_small = (m_in[WIDTH-1:1] == '0);

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign inv_w   = (r_pos && (r_u0 != '0)) ? (r_m - r_u0) : r_u0;
    assign inv_ext = {{DATA_W{1'b0}}, inv_w};

    mie_divunit #(
        .WIDTH (WIDTH)
    ) u_divunit (
        .i_clk  (i_clk),
        .i_cmd  (du_cmd),
        .i_rem  (ld_rem),
        .i_div  (ld_div),
        .i_uacc (ld_uacc),
        .i_ush  (ld_ush),
        .o_rem  (du_rem),
        .o_uacc (du_uacc),
        .o_stat (du_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = m_small ? ST_FIN : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (!du_stat.grow) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                if (du_stat.last) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                n_state = (du_rem == '0) ? ST_FIX : ST_SHIFT;
            end
            ST_FIX: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        du_cmd  = '0;
        ld_rem  = a_in;
        ld_div  = m_in;
        ld_uacc = '0;
        ld_ush  = '0;
        case (r_state)
            ST_IDLE: begin
                du_cmd.load = in_acc && !m_small;
            end
            ST_SHIFT: begin
                du_cmd.shift = du_stat.grow;
            end
            ST_SUB: begin
                du_cmd.sub = 1'b1;
            end
            ST_POST: begin
                du_cmd.load = (du_rem != '0);
                ld_rem      = r_red ? r_m : r_r1;
                ld_div      = du_rem;
                ld_uacc     = r_red ? '0 : r_u1;
                ld_ush      = r_red ? {{(WIDTH-1){1'b0}}, 1'b1} : du_uacc;
            end
            default: begin
                du_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_m    <= m_in;
                    r_fail <= m_small;
                    r_red  <= 1'b1;
                    r_pos  <= 1'b1;
                    r_u0   <= '0;
                end
            end
            ST_POST: begin
                r_r1 <= du_rem;
                if (r_red) begin
                    r_r0  <= r_m;
                    r_u0  <= '0;
                    r_u1  <= {{(WIDTH-1){1'b0}}, 1'b1};
                    r_red <= 1'b0;
                end else begin
                    r_r0  <= r_r1;
                    r_u0  <= r_u1;
                    r_u1  <= du_uacc;
                    r_pos <= !r_pos;
                end
            end
            ST_FIX: begin
                r_fail <= (r_r0 != {{(WIDTH-1){1'b0}}, 1'b1});
                r_u0   <= (r_u0 >= r_m) ? (r_u0 - r_m) : r_u0;
            end
            ST_FIN: begin
                if (out_free) begin
                    r_out.no_inverse <= r_fail;
                    r_out.inverse    <= r_fail ? '0 : inv_ext[DATA_W-1:0];
                end
            end
            default: begin
                r_fail <= r_fail;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_gcd_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_fail) |-> (r_r0 == {{(WIDTH-1){1'b0}}, 1'b1}))
        else $error("inverse reported without unit gcd");

    a_coef_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_fail) |-> (r_u0 < r_m))
        else $error("coefficient not reduced below modulus");

    a_inv_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.no_inverse) |-> (o_out_data.inverse != '0))
        else $error("zero inverse without no_inverse flag");
`endif

endmodule

[tb/mie_inverse_check.sv]
// Result checker for the modular inverse block: predicts the inverse of each
// accepted input word and compares it with the next output word.
// Depends on mie_pkg.
`timescale 1ns / 1ps

module mie_inverse_check import mie_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_MAX = 10;

    t_out inverse_q[$];
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic t_out euclid_inverse(t_in word);
        logic [63:0] mask;
        logic [63:0] m;
        logic [63:0] r_prev;
        logic [63:0] r_cur;
        logic [63:0] r_next;
        logic [63:0] c_prev;
        logic [63:0] c_cur;
        logic [63:0] c_next;
        logic [63:0] quo;
        logic        cur_pos;
        t_out        res;
        mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
        m = 64'(word.modulus) & mask;
        res = '0;
        res.no_inverse = 1'b1;
        if (m < 64'd2) begin
            return res;
        end
        r_prev  = m;
        r_cur   = (64'(word.value) & mask) % m;
        c_prev  = 64'd0;
        c_cur   = 64'd1;
        cur_pos = 1'b1;
        while (r_cur != 64'd0) begin
            quo     = r_prev / r_cur;
            r_next  = r_prev - quo * r_cur;
            c_next  = c_prev + quo * c_cur;
            r_prev  = r_cur;
            r_cur   = r_next;
            c_prev  = c_cur;
            c_cur   = c_next;
            cur_pos = !cur_pos;
        end
        if (r_prev != 64'd1) begin
            return res;
        end
        c_prev = c_prev % m;
        res.no_inverse = 1'b0;
        // lift a negative coefficient by the modulus
        res.inverse = (cur_pos && c_prev != 64'd0) ? DATA_W'(m - c_prev) : DATA_W'(c_prev);
        return res;
    endfunction

    task automatic note_mismatch(input string what, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("%0t: %s: expected inverse %h no_inverse %b, got inverse %h no_inverse %b",
                     $time, what, want.inverse, want.no_inverse, got.inverse, got.no_inverse);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            inverse_q.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                inverse_q.insert(inverse_q.size(), euclid_inverse(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (inverse_q.size() == 0) begin
                    note_mismatch("word with nothing outstanding", '0, i_out_data);
                end else begin
                    want = inverse_q.pop_front();
                    if (want.inverse != i_out_data.inverse
                            || want.no_inverse != i_out_data.no_inverse) begin
                        note_mismatch("wrong word", want, i_out_data);
                    end
                end
            end
            o_pending <= inverse_q.size();
        end
    end

endmodule

[tb/tb_modular_inverse_euclid.sv]
// Testbench top for modular_inverse_euclid: clock, reset, input words and
// output back-pressure, verdict. Depends on mie_pkg and mie_inverse_check.
`timescale 1ns / 1ps

module tb_modular_inverse_euclid import mie_pkg::*;;

    localparam int WIDTH       = 32;
    localparam int N_RANDOM    = 780;
    localparam int HOLD_OFF    = 1500;
    localparam int DRAIN       = 400;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;
    int   fail_count;
    int   pending;
    int   words_sent  = 0;
    int   cycle_count = 0;
    bit   calm        = 1'b0;
    bit   held_off    = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    modular_inverse_euclid #(
        .WIDTH(WIDTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    mie_inverse_check #(
        .WIDTH(WIDTH)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 120);
    endfunction

    function automatic t_in pair(input logic [31:0] value, input logic [31:0] modulus);
        t_in w;
        w.value   = value;
        w.modulus = modulus;
        return w;
    endfunction

    function automatic t_in random_word();
        t_in         w;
        int unsigned f;
        logic [31:0] fa;
        logic [31:0] fb;
        logic [31:0] t;
        w.value   = $urandom;
        w.modulus = $urandom;
        case ($urandom_range(0, 11))
            0: w.modulus = $urandom_range(2, 255);
            1: w.modulus = $urandom | 32'h8000_0001;
            2: w.modulus = 32'd1 << $urandom_range(1, 31);
            3: w.modulus = $urandom_range(0, 1);
            4: begin
                f = $urandom_range(2, 50);
                w.modulus = f * $urandom_range(1, 80_000_000);
                w.value   = f * $urandom_range(0, 80_000_000);
            end
            5: w.value = w.modulus + $urandom_range(0, 2) - 32'd1;
            6: begin
                fa = 32'd1;
                fb = 32'd1;
                repeat ($urandom_range(1, 45)) begin
                    t  = fa + fb;
                    fa = fb;
                    fb = t;
                end
                if ($urandom_range(0, 1) == 0) begin
                    w = pair(fa, fb);
                end else begin
                    w = pair(fb, fa);
                end
            end
            7: w.value = $urandom_range(0, 15);
            8: w.modulus = $urandom_range(2, 65535);
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input t_in w);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do begin
            @(posedge clk);
        end while (in_stall);
        words_sent++;
    endtask

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pair(32'd5, 32'd0));
        send_word(pair(32'hFFFF_FFFF, 32'd1));
        send_word(pair(32'd1, 32'd2));
        send_word(pair(32'd0, 32'd2));
        send_word(pair(32'd3, 32'd7));
        send_word(pair(32'd0, 32'd13));
        send_word(pair(32'd13, 32'd13));
        send_word(pair(32'hFFFF_FFFF, 32'd10));
        send_word(pair(32'hFFFF_FFFE, 32'd7));
        send_word(pair(32'd6, 32'd9));
        send_word(pair(32'd1, 32'hFFFF_FFFF));
        send_word(pair(32'd2, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFE, 32'hFFFF_FFFF));
        send_word(pair(32'hFFFF_FFFD, 32'hFFFF_FFFE));
        send_word(pair(32'd1836311903, 32'd2971215073));
        send_word(pair(32'd2971215073, 32'd1836311903));
        send_word(pair(32'd3, 32'd4294967291));
        send_word(pair(32'h7FFF_FFFF, 32'h8000_0000));
        send_word(pair(32'h8000_0000, 32'h8000_0001));
        send_word(pair(32'h1234_5678, 32'h8000_0000));
        send_word(pair(32'hAAAA_AAAA, 32'h5555_5555));
        send_word(pair(32'h5555_5555, 32'hAAAA_AAAB));

        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 400 && k < 480);
            send_word(random_word());
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : backpressure
        int n;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (calm) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                // hold off long enough for the block to fill and stall its input
                if (!held_off && words_sent >= 150) begin
                    held_off = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF) @(posedge clk);
                end
                n = idle_len();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat (1 + idle_len()) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
rtl/mie_pkg.sv
rtl/mie_divunit.sv
rtl/modular_inverse_euclid.sv
tb/mie_inverse_check.sv
tb/tb_modular_inverse_euclid.sv
